### hw/rtl/aarf_rate_adaptation_macros.svh
// Assertion macros shared by the rate adaptation checker.
`ifndef AARF_RATE_ADAPTATION_MACROS_SVH
`define AARF_RATE_ADAPTATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AARF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aarf checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define AARF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aarf checker: next-cycle property failed");

`endif

### hw/rtl/aarf_pkg.sv
// Shared types and constants of the rate adaptation block.
`timescale 1ns / 1ps

package aarf_pkg;

	// Configuration register widths and port geometry.
	localparam int RATE_COUNT_W = 5;
	localparam int LIMIT_W      = 16;
	localparam int FACTOR_W     = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_RATE_COUNT       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_TIMEOUT     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SUCCESS_THR  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SUCCESS_THR  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_FACTOR = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_FACTOR   = 3'd5;

	// Register reset values.
	localparam logic [RATE_COUNT_W-1:0] RST_RATE_COUNT       = 5'd8;
	localparam logic [LIMIT_W-1:0]      RST_BASE_TIMEOUT     = 16'd15;
	localparam logic [LIMIT_W-1:0]      RST_MIN_SUCCESS_THR  = 16'd10;
	localparam logic [LIMIT_W-1:0]      RST_MAX_SUCCESS_THR  = 16'd50;
	localparam logic [FACTOR_W-1:0]     RST_THRESHOLD_FACTOR = 4'd2;
	localparam logic [FACTOR_W-1:0]     RST_TIMEOUT_FACTOR   = 4'd2;

	// Defaults for the top-level parameters.
	localparam int DEF_RATE_SLOTS = 16;
	localparam int DEF_COUNT_BITS = 16;

	// Retry chain shape.
	localparam int CHAIN_STAGES = 4;
	localparam int RATE_OUT_W   = 4;
	localparam int TRIES_W      = 2;

	localparam logic [TRIES_W-1:0] TRIES_SHORT = 2'd1;
	localparam logic [TRIES_W-1:0] TRIES_LONG  = 2'd2;

	// Stream data widths.
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic [RATE_COUNT_W-1:0] rate_count;
		logic [LIMIT_W-1:0]      base_timeout;
		logic [LIMIT_W-1:0]      min_success_threshold;
		logic [LIMIT_W-1:0]      max_success_threshold;
		logic [FACTOR_W-1:0]     threshold_factor;
		logic [FACTOR_W-1:0]     timeout_factor;
	} cfg_t;

	typedef struct packed {
		logic                  in_recovery;
		logic [TRIES_W-1:0]    first_tries;
		logic [RATE_OUT_W-1:0] rate_fourth;
		logic [RATE_OUT_W-1:0] rate_third;
		logic [RATE_OUT_W-1:0] rate_second;
		logic [RATE_OUT_W-1:0] rate_first;
	} res_t;

endpackage

### hw/rtl/aarf_rate_adaptation.sv
// Top level of the adaptive auto rate fallback block for one station.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one item per transmit attempt: s_tdata[0] is 1 when
// the attempt was acknowledged and 0 when it failed. For each item the master
// stream returns exactly one item with the four-stage retry chain, the try count
// for the first stage and the recovery flag, all taken from the station state
// after that attempt has been applied.
// An item is registered on acceptance, and its result is registered into the output
// register when the input stage moves on, which raises m_tvalid.
// The state update is a single compare-and-update step, so one item is taken in
// every cycle while the master side keeps accepting.
// When the receiver stalls, the result waits in the output register and one more
// item waits in the input register; s_tready falls only when both are full.
// The configuration port writes one register per cycle with cfg_wen high; it is
// meant to be written while no item is in flight and does not touch the state.
// Reset (arst_n low) clears both registers, sets the rate to the lowest entry,
// clears the counters and the recovery flag, loads the register reset values
// and seeds the threshold and timeout from the reset minimums.
module aarf_rate_adaptation #(
	parameter int RATE_SLOTS = aarf_pkg::DEF_RATE_SLOTS,
	parameter int COUNT_BITS = aarf_pkg::DEF_COUNT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata fields from bit 0: attempt_ok[0], zero fill [7:1].
	input  logic [aarf_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata fields from bit 0: rate_first[3:0], rate_second[7:4],
	// rate_third[11:8], rate_fourth[15:12], first_tries[17:16],
	// in_recovery[18], zero fill [23:19].
	output logic [aarf_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_wen,
	input  logic [aarf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [aarf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int RES_W = $bits(aarf_pkg::res_t);

	aarf_pkg::cfg_t cfg;
	aarf_pkg::res_t res_next;
	aarf_pkg::res_t res_q;

	logic valid_s1;
	logic ok_s1;
	logic m_valid_q;
	logic advance;
	logic step;
	logic in_accept;

	// The input stage moves on whenever the output register is empty or being drained.
	assign advance   = !m_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			valid_s1  <= in_accept || (valid_s1 && !advance);
			m_valid_q <= step || (m_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ok_s1 <= s_tdata[0];
		end
		if (step) begin
			res_q <= res_next;
		end
	end

	aarf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aarf_update #(
		.RATE_SLOTS (RATE_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.attempt_ok (ok_s1),
		.cfg        (cfg),
		.res        (res_next)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(aarf_pkg::OUT_DATA_W-RES_W){1'b0}}, res_q};

endmodule

### hw/rtl/aarf_cfg_regs.sv
// Configuration register file of the rate adaptation block.
`timescale 1ns / 1ps

module aarf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [aarf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [aarf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output aarf_pkg::cfg_t                   cfg
);

	aarf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_count            <= aarf_pkg::RST_RATE_COUNT;
			cfg_q.base_timeout          <= aarf_pkg::RST_BASE_TIMEOUT;
			cfg_q.min_success_threshold <= aarf_pkg::RST_MIN_SUCCESS_THR;
			cfg_q.max_success_threshold <= aarf_pkg::RST_MAX_SUCCESS_THR;
			cfg_q.threshold_factor      <= aarf_pkg::RST_THRESHOLD_FACTOR;
			cfg_q.timeout_factor        <= aarf_pkg::RST_TIMEOUT_FACTOR;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				aarf_pkg::REG_RATE_COUNT: begin
					cfg_q.rate_count <= cfg_wdata[aarf_pkg::RATE_COUNT_W-1:0];
				end
				aarf_pkg::REG_BASE_TIMEOUT: begin
					cfg_q.base_timeout <= cfg_wdata[aarf_pkg::LIMIT_W-1:0];
				end
				aarf_pkg::REG_MIN_SUCCESS_THR: begin
					cfg_q.min_success_threshold <= cfg_wdata[aarf_pkg::LIMIT_W-1:0];
				end
				aarf_pkg::REG_MAX_SUCCESS_THR: begin
					cfg_q.max_success_threshold <= cfg_wdata[aarf_pkg::LIMIT_W-1:0];
				end
				aarf_pkg::REG_THRESHOLD_FACTOR: begin
					cfg_q.threshold_factor <= cfg_wdata[aarf_pkg::FACTOR_W-1:0];
				end
				aarf_pkg::REG_TIMEOUT_FACTOR: begin
					cfg_q.timeout_factor <= cfg_wdata[aarf_pkg::FACTOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/aarf_update.sv
// Station state and its per-attempt update for the rate adaptation block.
`timescale 1ns / 1ps

module aarf_update #(
	parameter int RATE_SLOTS = aarf_pkg::DEF_RATE_SLOTS,
	parameter int COUNT_BITS = aarf_pkg::DEF_COUNT_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           attempt_ok,
	input  aarf_pkg::cfg_t cfg,
	output aarf_pkg::res_t res
);

	localparam int RW  = $clog2(RATE_SLOTS);
	localparam int CW  = ((RW > aarf_pkg::RATE_COUNT_W) ? RW : aarf_pkg::RATE_COUNT_W) + 1;
	localparam int PW  = COUNT_BITS + aarf_pkg::FACTOR_W;
	localparam int SW  = (PW > aarf_pkg::LIMIT_W) ? PW : aarf_pkg::LIMIT_W;
	localparam logic [SW-1:0] CNT_MAX = {{(SW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
	localparam logic [CW-1:0] RATES_TOP = CW'(RATE_SLOTS);

	function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [SW-1:0] v);
		if (v > CNT_MAX) begin
			return CNT_MAX[COUNT_BITS-1:0];
		end else begin
			return v[COUNT_BITS-1:0];
		end
	endfunction

	logic [RW-1:0]         rate_q, rate_n;
	logic [COUNT_BITS-1:0] timer_q, timer_n, timer_inc;
	logic [COUNT_BITS-1:0] succ_q, succ_n, succ_inc;
	logic [COUNT_BITS-1:0] thr_q, thr_n;
	logic [COUNT_BITS-1:0] tlim_q, tlim_n;
	logic                  fail_q, fail_n;
	logic                  rec_q, rec_n;

	logic [PW-1:0]         to_prod, thr_prod;
	logic [SW-1:0]         to_floor, thr_cap;
	logic [COUNT_BITS-1:0] to_scaled, thr_scaled, to_min, thr_min;
	logic [CW-1:0]         rate_up, rate_ext;
	logic                  can_up;
	logic [RW-1:0]         rate_down;

	always_comb begin
		timer_inc = (timer_q == CNT_MAX[COUNT_BITS-1:0]) ? timer_q : timer_q + 1'b1;
		succ_inc  = (succ_q == CNT_MAX[COUNT_BITS-1:0]) ? succ_q : succ_q + 1'b1;

		// Scaling after a failed probation: timeout floored, threshold capped.
		to_prod  = PW'(tlim_q) * PW'(cfg.timeout_factor);
		thr_prod = PW'(thr_q) * PW'(cfg.threshold_factor);
		to_floor = (SW'(to_prod) < SW'(cfg.min_success_threshold)) ?
			SW'(cfg.min_success_threshold) : SW'(to_prod);
		thr_cap  = (SW'(thr_prod) > SW'(cfg.max_success_threshold)) ?
			SW'(cfg.max_success_threshold) : SW'(thr_prod);
		to_scaled  = sat_cnt(to_floor);
		thr_scaled = sat_cnt(thr_cap);
		to_min     = sat_cnt(SW'(cfg.base_timeout));
		thr_min    = sat_cnt(SW'(cfg.min_success_threshold));

		rate_up   = CW'(rate_q) + 1'b1;
		can_up    = (rate_up < CW'(cfg.rate_count)) && (rate_up < RATES_TOP);
		rate_down = (rate_q != '0) ? rate_q - 1'b1 : rate_q;

		rate_n  = rate_q;
		timer_n = timer_q;
		succ_n  = succ_q;
		thr_n   = thr_q;
		tlim_n  = tlim_q;
		fail_n  = fail_q;
		rec_n   = rec_q;

		if (step) begin
			if (attempt_ok) begin
				timer_n = timer_inc;
				succ_n  = succ_inc;
				fail_n  = 1'b0;
				rec_n   = 1'b0;
				if (((succ_inc >= thr_q) || (timer_inc >= tlim_q)) && can_up) begin
					rate_n  = rate_up[RW-1:0];
					timer_n = '0;
					succ_n  = '0;
					rec_n   = 1'b1;
				end
			end else begin
				succ_n = '0;
				priority if (rec_q) begin
					// Probation failed: back off and demand more before the next raise.
					tlim_n  = to_scaled;
					thr_n   = thr_scaled;
					timer_n = '0;
					fail_n  = 1'b0;
					rate_n  = rate_down;
				end else if (fail_q) begin
					// Second failure in a row: back off and restore the minimums.
					tlim_n  = to_min;
					thr_n   = thr_min;
					timer_n = '0;
					fail_n  = 1'b0;
					rate_n  = rate_down;
				end else begin
					timer_n = timer_inc;
					fail_n  = 1'b1;
				end
			end
		end

		// Retry chain from the updated rate, each stage one rate lower.
		rate_ext = CW'(rate_n);
		res.rate_first  = rate_ext[aarf_pkg::RATE_OUT_W-1:0];
		res.rate_second = '0;
		res.rate_third  = '0;
		res.rate_fourth = '0;
		if (aarf_pkg::CHAIN_STAGES > 1) begin
			res.rate_second = (rate_ext > CW'(1)) ?
				rate_ext[aarf_pkg::RATE_OUT_W-1:0] - 4'd1 : 4'd0;
		end
		if (aarf_pkg::CHAIN_STAGES > 2) begin
			res.rate_third = (rate_ext > CW'(2)) ?
				rate_ext[aarf_pkg::RATE_OUT_W-1:0] - 4'd2 : 4'd0;
		end
		if (aarf_pkg::CHAIN_STAGES > 3) begin
			res.rate_fourth = (rate_ext > CW'(3)) ?
				rate_ext[aarf_pkg::RATE_OUT_W-1:0] - 4'd3 : 4'd0;
		end
		res.first_tries = (rec_n || fail_n) ? aarf_pkg::TRIES_SHORT : aarf_pkg::TRIES_LONG;
		res.in_recovery = rec_n;
	end

	// The limits come out of reset at the register reset values, cut to the counter width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= '0;
			timer_q <= '0;
			succ_q  <= '0;
			thr_q   <= COUNT_BITS'(aarf_pkg::RST_MIN_SUCCESS_THR);
			tlim_q  <= COUNT_BITS'(aarf_pkg::RST_BASE_TIMEOUT);
			fail_q  <= 1'b0;
			rec_q   <= 1'b0;
		end else begin
			rate_q  <= rate_n;
			timer_q <= timer_n;
			succ_q  <= succ_n;
			thr_q   <= thr_n;
			tlim_q  <= tlim_n;
			fail_q  <= fail_n;
			rec_q   <= rec_n;
		end
	end

endmodule

### hw/rtl/aarf_checker.sv
// Port-level checker of the rate adaptation block and its bind.
`timescale 1ns / 1ps
`include "aarf_rate_adaptation_macros.svh"

module aarf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [aarf_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [3:0] last_rate_q;
	logic       last_rec_q;
	logic       have_q;
	logic [3:0] cur_rate;
	logic [3:0] last_up;
	logic       cur_rec;
	logic       out_hs;
	logic       stalled;
	logic       rate_near;
	logic       rec_rise;

	assign cur_rate  = m_tdata[3:0];
	assign cur_rec   = m_tdata[18];
	assign last_up   = last_rate_q + 4'd1;
	assign out_hs    = m_tvalid && m_tready;
	assign stalled   = m_tvalid && !m_tready;
	assign rate_near = (cur_rate == last_rate_q) || (cur_rate == last_up) ||
		(last_rate_q == cur_rate + 4'd1);
	assign rec_rise  = cur_rec && !last_rec_q;

	// Remember the last delivered result to compare against the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rate_q <= '0;
			last_rec_q  <= 1'b0;
			have_q      <= 1'b0;
		end else if (out_hs) begin
			last_rate_q <= cur_rate;
			last_rec_q  <= cur_rec;
			have_q      <= 1'b1;
		end
	end

	`AARF_ASSERT_NEXT(a_stall_holds, clk, arst_n, stalled, m_tvalid && $stable(m_tdata))
	`AARF_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`AARF_ASSERT_NOW(a_rate_moves_by_one, clk, arst_n, m_tvalid && have_q, rate_near)
	`AARF_ASSERT_NOW(a_recovery_on_raise, clk, arst_n, m_tvalid && have_q && rec_rise, cur_rate == last_up)

endmodule

bind aarf_rate_adaptation aarf_checker u_aarf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### test/aarf_rate_adaptation_tb.sv
// Self-checking testbench for the adaptive auto rate fallback block.
`timescale 1ns / 1ps

// The testbench sends transmit outcomes (acknowledged or failed) into the
// block and checks each returned retry chain against its own model of the
// rate state. The model tracks the same rate index, counters, recovery flag,
// threshold and timeout as the block. It is updated at the moment an outcome
// is accepted, and the predicted chain is queued. Each result taken from the
// master side is compared with the oldest queued chain, field by field.
//
// The run has three parts.
//  - A short directed part. It covers the floor of the rate at zero, a step up
//    from the success threshold, a failed recovery that scales the limits, a
//    rate count above the maximum, a rate count lowered below the current
//    index, zero factors that leave a zero threshold, and rate counts of zero
//    and one.
//  - Random phases. Each phase writes every register with a fresh setting,
//    extremes included, and then sends outcomes with a success rate chosen per
//    phase, so that the rate climbs, falls back and sits in recovery.
//  - A final part with no idling. It ends with a run of successes at a single
//    usable rate under full-scale limits, where the rate never steps up.
// Registers are only written once the block has drained. The drain between
// phases also makes the sender wait for every outstanding result.
module aarf_rate_adaptation_tb;

	localparam int unsigned COUNT_MAX = (1 << aarf_pkg::DEF_COUNT_BITS) - 1;
	localparam int unsigned RANDOM_PHASES = 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	// s_tdata fields from bit 0: attempt_ok[0], zero fill [7:1].
	logic [aarf_pkg::IN_DATA_W-1:0]   s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// m_tdata fields from bit 0: rate_first[3:0], rate_second[7:4],
	// rate_third[11:8], rate_fourth[15:12], first_tries[17:16],
	// in_recovery[18], zero fill [23:19].
	logic [aarf_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic                             cfg_wen = 1'b0;
	logic [aarf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [aarf_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	aarf_rate_adaptation DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Outcomes waiting to be sent (1 = acknowledged) and chains still owed.
	bit             outcome_queue[$];
	aarf_pkg::res_t chain_due[$];

	// Idling is switched off for the last part of the run.
	bit idle_enable = 1'b1;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	int unsigned fault_count = 0;

	// Mirror of the configuration registers.
	logic [aarf_pkg::RATE_COUNT_W-1:0] lim_rates;
	logic [aarf_pkg::LIMIT_W-1:0]      lim_base_tmo;
	logic [aarf_pkg::LIMIT_W-1:0]      lim_min_thr;
	logic [aarf_pkg::LIMIT_W-1:0]      lim_max_thr;
	logic [aarf_pkg::FACTOR_W-1:0]     lim_thr_factor;
	logic [aarf_pkg::FACTOR_W-1:0]     lim_timeout_factor;

	// Mirror of the station state.
	logic [aarf_pkg::RATE_OUT_W-1:0] rate_idx;
	logic [aarf_pkg::LIMIT_W-1:0]    tx_timer;
	logic [aarf_pkg::LIMIT_W-1:0]    ack_run;
	logic [1:0]                      nack_run;
	logic                            probing;
	logic [aarf_pkg::LIMIT_W-1:0]    ack_goal;
	logic [aarf_pkg::LIMIT_W-1:0]    timer_goal;

	function automatic logic [aarf_pkg::LIMIT_W-1:0] bump_sat(logic [aarf_pkg::LIMIT_W-1:0] v);
		return (v == aarf_pkg::LIMIT_W'(COUNT_MAX)) ? v : v + 1'b1;
	endfunction

	// Applies one outcome to the mirrored state and returns the chain that
	// the block must report for it.
	function automatic aarf_pkg::res_t apply_outcome(bit acked);
		int unsigned top;
		int unsigned scaled_timer;
		int unsigned scaled_goal;
		logic [aarf_pkg::RATE_OUT_W-1:0] r;
		aarf_pkg::res_t chain;
		top = (32'(lim_rates) > aarf_pkg::DEF_RATE_SLOTS) ? aarf_pkg::DEF_RATE_SLOTS
				: 32'(lim_rates);
		tx_timer = bump_sat(tx_timer);
		if (acked) begin
			ack_run = bump_sat(ack_run);
			nack_run = 2'd0;
			probing = 1'b0;
			// The rate only rises while a higher entry exists.
			if ((ack_run >= ack_goal || tx_timer >= timer_goal) &&
					32'(rate_idx) + 1 < top) begin
				rate_idx = rate_idx + 1'b1;
				tx_timer = '0;
				ack_run = '0;
				probing = 1'b1;
			end
		end else begin
			nack_run = nack_run + 1'b1;
			ack_run = '0;
			if (probing) begin
				// A failed probe backs off: timeout and threshold scaled by their factors.
				// The recovery flag itself stays set until the next success.
				scaled_timer = 32'(timer_goal) * 32'(lim_timeout_factor);
				scaled_goal = 32'(ack_goal) * 32'(lim_thr_factor);
				if (scaled_timer < 32'(lim_min_thr))
					scaled_timer = 32'(lim_min_thr);
				if (scaled_goal > 32'(lim_max_thr))
					scaled_goal = 32'(lim_max_thr);
				timer_goal = (scaled_timer > COUNT_MAX) ? aarf_pkg::LIMIT_W'(COUNT_MAX)
						: aarf_pkg::LIMIT_W'(scaled_timer);
				ack_goal = (scaled_goal > COUNT_MAX) ? aarf_pkg::LIMIT_W'(COUNT_MAX)
						: aarf_pkg::LIMIT_W'(scaled_goal);
				tx_timer = '0;
				nack_run = 2'd0;
				if (rate_idx != 0)
					rate_idx = rate_idx - 1'b1;
			end else if (nack_run >= 2'd2) begin
				timer_goal = lim_base_tmo;
				ack_goal = lim_min_thr;
				tx_timer = '0;
				nack_run = 2'd0;
				if (rate_idx != 0)
					rate_idx = rate_idx - 1'b1;
			end
		end
		// Each later stage of the chain is one rate lower, stopping at zero.
		r = rate_idx;
		chain.rate_first = r;
		r = (r != 0) ? r - 1'b1 : r;
		chain.rate_second = r;
		r = (r != 0) ? r - 1'b1 : r;
		chain.rate_third = r;
		r = (r != 0) ? r - 1'b1 : r;
		chain.rate_fourth = r;
		chain.first_tries = (probing || nack_run != 0) ? aarf_pkg::TRIES_SHORT
				: aarf_pkg::TRIES_LONG;
		chain.in_recovery = probing;
		return chain;
	endfunction

	function automatic string chain_text(aarf_pkg::res_t c);
		return $sformatf("rates %0d/%0d/%0d/%0d tries %0d recovery %0d", c.rate_first,
				c.rate_second, c.rate_third, c.rate_fourth, c.first_tries, c.in_recovery);
	endfunction

	// Source side: present the next queued outcome, with random gaps.
	// The prediction is made at the edge where the outcome is accepted.
	always @(posedge clk) begin : feed_outcomes
		logic                           next_valid;
		logic [aarf_pkg::IN_DATA_W-1:0] next_data;
		next_valid = s_tvalid;
		next_data = s_tdata;
		if (s_tvalid && s_tready) begin
			chain_due.push_back(apply_outcome(s_tdata[0]));
			next_valid = 1'b0;
		end
		if (arst_n && !next_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (outcome_queue.size() > 0) begin
				if (idle_enable && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 13);
				end else begin
					next_valid = 1'b1;
					next_data = '0;
					next_data[0] = outcome_queue.pop_front();
				end
			end
		end
		s_tvalid <= next_valid;
		s_tdata <= next_data;
	end

	// Sink side: random stall bursts, then compare each result in order.
	always @(posedge clk) begin : check_chains
		aarf_pkg::res_t got;
		aarf_pkg::res_t want;
		if (m_tvalid && m_tready) begin
			got = aarf_pkg::res_t'(m_tdata[$bits(aarf_pkg::res_t)-1:0]);
			if (chain_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: result with nothing outstanding: %s", $realtime,
							chain_text(got));
			end else begin
				want = chain_due.pop_front();
				if (got.rate_first !== want.rate_first ||
						got.rate_second !== want.rate_second ||
						got.rate_third !== want.rate_third ||
						got.rate_fourth !== want.rate_fourth ||
						got.first_tries !== want.first_tries ||
						got.in_recovery !== want.in_recovery) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: chain mismatch, expected %s, got %s", $realtime,
								chain_text(want), chain_text(got));
				end
			end
		end
		if (take_gap > 0) begin
			take_gap--;
			m_tready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			take_gap = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(logic [aarf_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[aarf_pkg::CFG_DATA_W-1:0];
		case (idx)
			aarf_pkg::REG_RATE_COUNT:       lim_rates = val[aarf_pkg::RATE_COUNT_W-1:0];
			aarf_pkg::REG_BASE_TIMEOUT:     lim_base_tmo = val[aarf_pkg::LIMIT_W-1:0];
			aarf_pkg::REG_MIN_SUCCESS_THR:  lim_min_thr = val[aarf_pkg::LIMIT_W-1:0];
			aarf_pkg::REG_MAX_SUCCESS_THR:  lim_max_thr = val[aarf_pkg::LIMIT_W-1:0];
			aarf_pkg::REG_THRESHOLD_FACTOR: lim_thr_factor = val[aarf_pkg::FACTOR_W-1:0];
			aarf_pkg::REG_TIMEOUT_FACTOR:   lim_timeout_factor = val[aarf_pkg::FACTOR_W-1:0];
			default: ;
		endcase
	endtask

	// Writes the whole register set; only called while the block is drained.
	task automatic program_limits(int unsigned rates, int unsigned min_tmo,
			int unsigned min_thr, int unsigned max_thr, int unsigned thr_f, int unsigned tmo_f);
		write_reg(aarf_pkg::REG_RATE_COUNT, rates);
		write_reg(aarf_pkg::REG_BASE_TIMEOUT, min_tmo);
		write_reg(aarf_pkg::REG_MIN_SUCCESS_THR, min_thr);
		write_reg(aarf_pkg::REG_MAX_SUCCESS_THR, max_thr);
		write_reg(aarf_pkg::REG_THRESHOLD_FACTOR, thr_f);
		write_reg(aarf_pkg::REG_TIMEOUT_FACTOR, tmo_f);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Queues outcomes written as a string: S for acknowledged, F for failed.
	task automatic queue_outcomes(string seq);
		for (int i = 0; i < seq.len(); i++)
			outcome_queue.push_back(seq[i] == "S");
	endtask

	// Holds the sender until every outstanding result has come back.
	task automatic drain();
		while (outcome_queue.size() > 0 || s_tvalid || chain_due.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Limit values lean toward small numbers so that steps happen often,
	// with zero and the full range mixed in.
	function automatic int unsigned pick_limit();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return COUNT_MAX;
			2: return $urandom_range(0, COUNT_MAX);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned odds;
		int unsigned len;
		lim_rates = aarf_pkg::RST_RATE_COUNT;
		lim_base_tmo = aarf_pkg::RST_BASE_TIMEOUT;
		lim_min_thr = aarf_pkg::RST_MIN_SUCCESS_THR;
		lim_max_thr = aarf_pkg::RST_MAX_SUCCESS_THR;
		lim_thr_factor = aarf_pkg::RST_THRESHOLD_FACTOR;
		lim_timeout_factor = aarf_pkg::RST_TIMEOUT_FACTOR;
		rate_idx = '0;
		tx_timer = '0;
		ack_run = '0;
		nack_run = 2'd0;
		probing = 1'b0;
		ack_goal = aarf_pkg::RST_MIN_SUCCESS_THR;
		timer_goal = aarf_pkg::RST_BASE_TIMEOUT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: two failures at the lowest rate, a climb on the
		// success threshold, a failed probe, then a pending single failure.
		queue_outcomes("FFSSSSSSSSSSFSSFS");
		drain();

		// Rate count above the maximum, saturated timeout after restore, a
		// climb to the top rate and a single failure there.
		program_limits(31, COUNT_MAX, 1, COUNT_MAX, 15, 15);
		queue_outcomes("FFSSSSSSSSSSSSSSSSF");
		drain();

		// Rate count lowered below the index: no further climb, only falls.
		program_limits(3, 20, 1, COUNT_MAX, 15, 15);
		queue_outcomes("SSSFF");
		drain();

		// Zero factors: a failed probe leaves a zero threshold and a timeout
		// floored to the minimum threshold, so every success steps up while a higher rate exists.
		program_limits(16, 5, 1, 7, 0, 0);
		queue_outcomes("FFSFSSS");
		drain();

		// Rate counts of zero and one never allow a step up.
		program_limits(0, 1, 1, 1, 1, 1);
		queue_outcomes("SSSFFS");
		drain();
		program_limits(1, 1, 0, 0, 1, 1);
		queue_outcomes("SSFS");
		drain();

		// Random phases, each under a new setting. The drain before each
		// write also holds the sender until every result is back.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_enable = ($urandom_range(0, 3) != 0);
			program_limits(($urandom_range(0, 1) != 0) ? $urandom_range(4, 16)
					: $urandom_range(0, 31), pick_limit(), pick_limit(), pick_limit(),
					$urandom_range(0, 15), $urandom_range(0, 15));
			odds = 2 << $urandom_range(0, 3);
			len = $urandom_range(90, 140);
			for (int i = 0; i < len; i++)
				outcome_queue.push_back($urandom_range(0, odds - 1) != 0);
			drain();
		end

		// Last part: no idling on either side.
		idle_enable = 1'b0;
		program_limits(16, $urandom_range(1, 30), $urandom_range(1, 10),
				$urandom_range(10, 200), $urandom_range(1, 15), $urandom_range(1, 15));
		for (int i = 0; i < 100; i++)
			outcome_queue.push_back($urandom_range(0, 7) != 0);
		drain();

		// A single usable rate with full-scale limits: successes keep
		// counting without ever stepping up.
		program_limits(1, COUNT_MAX, COUNT_MAX, COUNT_MAX, 15, 15);
		queue_outcomes("SFF");
		for (int i = 0; i < 20; i++)
			outcome_queue.push_back(1'b1);
		queue_outcomes("FSFF");
		drain();

		if (fault_count == 0 && chain_due.size() == 0)
			$display("[aarf_rate_adaptation] OK");
		else
			$display("[aarf_rate_adaptation] ERROR");
		$finish;
	end

	// Far above the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("[aarf_rate_adaptation] ERROR");
		$finish;
	end

endmodule
